/* sv/satc_pkg.sv */
`default_nettype none

package satc_pkg;

  localparam int MODE_W   = 3;
  localparam int LAMP_W   = 2;
  localparam int LEDS     = 12;
  localparam int CHASE_W  = 13;
  localparam int POS_W    = 4;
  localparam int PWM_W    = 7;
  localparam int BUZZ_W   = 24;
  localparam int GREEN_W  = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam int BUZZ_SCALE         = 100;
  localparam int GREEN_NORMAL_HALF  = 10000;
  localparam int GREEN_SETTING_HALF = 2000;

  localparam int CHASE_BASE  = 5030;
  localparam int CHASE_STEP  = 50;
  localparam int CHASE_WRAP  = 13;
  localparam int PWM_PERIOD  = 100;
  localparam int SPEED_MAX   = 100;
  localparam int BRIGHT_RST  = 100;
  localparam int GROUPS_RST  = 1;

  localparam logic [MODE_W-1:0] MODE_PRESTART = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SETTING  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_NORMAL   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RED      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_YELLOW   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_GREEN    = 3'd5;

  localparam logic [LAMP_W-1:0] LAMP_NONE   = 2'd0;
  localparam logic [LAMP_W-1:0] LAMP_RED    = 2'd1;
  localparam logic [LAMP_W-1:0] LAMP_YELLOW = 2'd2;
  localparam logic [LAMP_W-1:0] LAMP_GREEN  = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GROUP_COUNT = 3'd0,
    REG_CHASE_SPEED = 3'd1,
    REG_BRIGHTNESS  = 3'd2,
    REG_BUZZ_ON     = 3'd3,
    REG_BUZZ_OFF    = 3'd4,
    REG_BUZZ_EN     = 3'd5,
    REG_RELAY_EN    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [2:0] group_count;
    logic [6:0] speed;
    logic [6:0] brightness;
    logic [7:0] buzz_on;
    logic [7:0] buzz_off;
    logic [2:0] buzz_en;
    logic [2:0] relay_en;
  } cfg_t;

  typedef struct packed {
    logic [LAMP_W-1:0] lamp;
    logic [LEDS-1:0]   led_mask;
    logic              buzzer_drive;
    logic              volume_max;
    logic              center_green;
    logic              relay;
  } result_t;

  // evenly spaced group of lit leds, rotated so the first sits at pos
  function automatic logic [LEDS-1:0] ring_pattern(input logic [POS_W-1:0] pos,
                                                   input logic [2:0] groups);
    logic [LEDS-1:0]   base;
    logic [2*LEDS-1:0] twice;
    logic [POS_W-1:0]  rot;
    case (groups)
      3'd1:    base = 12'b0000_0000_0001;
      3'd2:    base = 12'b0000_0100_0001;
      3'd3:    base = 12'b0001_0001_0001;
      3'd4:    base = 12'b0010_0100_1001;
      default: base = '0;
    endcase
    rot   = pos - POS_W'(1);
    twice = {base, base} << rot;
    if (pos == '0 || pos > POS_W'(LEDS)) begin
      return '0;
    end
    return twice[2*LEDS-1:LEDS];
  endfunction

endpackage

`default_nettype wire

/* sv/satc_core.sv */
`default_nettype none

module satc_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step,
  input  wire logic [satc_pkg::MODE_W-1:0]  work_mode,
  input  wire logic                         loud,
  input  wire satc_pkg::cfg_t               cfg,
  output satc_pkg::result_t                 res
);
  import satc_pkg::*;

  localparam logic [GREEN_W-1:0] NORMAL_HALF  = GREEN_W'(GREEN_NORMAL_HALF);
  localparam logic [GREEN_W-1:0] NORMAL_FULL  = GREEN_W'(2 * GREEN_NORMAL_HALF);
  localparam logic [GREEN_W-1:0] SETTING_HALF = GREEN_W'(GREEN_SETTING_HALF);
  localparam logic [GREEN_W-1:0] SETTING_FULL = GREEN_W'(2 * GREEN_SETTING_HALF);

  logic [CHASE_W-1:0] chase_wait_r, chase_wait_nxt;
  logic [POS_W-1:0]   chase_pos_r, chase_pos_nxt;
  logic [LEDS-1:0]    led_pattern_r, led_pattern_nxt;
  logic [PWM_W-1:0]   pwm_phase_r, pwm_phase_nxt;
  logic [LAMP_W-1:0]  lamp_r, lamp_nxt;
  logic [BUZZ_W-1:0]  buzz_phase_r, buzz_phase_nxt;
  logic               drive_r, drive_nxt;
  logic               volume_r, volume_nxt;
  logic [GREEN_W-1:0] green_phase_r, green_phase_nxt;
  logic               green_r, green_nxt;

  logic               colour;
  logic [2:0]         colour_bit;
  logic [CHASE_W-1:0] period;
  logic [PWM_W-1:0]   pwm_inc;
  logic [BUZZ_W-1:0]  on_count, end_count, buzz_inc;
  logic [GREEN_W-1:0] green_inc, half, full;

  always_comb begin
    colour = work_mode inside {[MODE_RED:MODE_GREEN]};
    case (work_mode)
      MODE_RED:    colour_bit = 3'b001;
      MODE_YELLOW: colour_bit = 3'b010;
      MODE_GREEN:  colour_bit = 3'b100;
      default:     colour_bit = 3'b000;
    endcase

    // chase
    chase_wait_nxt  = chase_wait_r;
    chase_pos_nxt   = chase_pos_r;
    led_pattern_nxt = led_pattern_r;
    period = CHASE_W'(CHASE_BASE) - CHASE_W'(cfg.speed) * CHASE_W'(CHASE_STEP);
    if (work_mode inside {[MODE_PRESTART:MODE_NORMAL]}) begin
      led_pattern_nxt = '0;
    end else if (chase_wait_r >= period) begin
      chase_pos_nxt = chase_pos_r + POS_W'(1);
      if (chase_pos_nxt >= POS_W'(CHASE_WRAP)) begin
        chase_pos_nxt = POS_W'(1);
      end
      if (cfg.speed != '0) begin
        led_pattern_nxt = ring_pattern(chase_pos_nxt, cfg.group_count);
      end
      chase_wait_nxt = '0;
    end else begin
      chase_wait_nxt = chase_wait_r + CHASE_W'(1);
    end

    // lamp pwm
    pwm_inc       = pwm_phase_r + PWM_W'(1);
    pwm_phase_nxt = pwm_inc;
    lamp_nxt      = lamp_r;
    if (pwm_inc > cfg.brightness) begin
      lamp_nxt = LAMP_NONE;
    end else begin
      case (work_mode)
        MODE_RED:    lamp_nxt = LAMP_RED;
        MODE_YELLOW: lamp_nxt = LAMP_YELLOW;
        MODE_GREEN:  lamp_nxt = LAMP_GREEN;
        default:     lamp_nxt = lamp_r;
      endcase
    end
    if (pwm_inc >= PWM_W'(PWM_PERIOD)) begin
      pwm_phase_nxt = '0;
    end

    // buzzer
    on_count  = BUZZ_W'(cfg.buzz_on) * BUZZ_W'(BUZZ_SCALE);
    end_count = BUZZ_W'({1'b0, cfg.buzz_on} + {1'b0, cfg.buzz_off}) * BUZZ_W'(BUZZ_SCALE);
    buzz_inc       = buzz_phase_r + BUZZ_W'(1);
    buzz_phase_nxt = buzz_phase_r;
    drive_nxt      = drive_r;
    volume_nxt     = volume_r;
    if (colour && (cfg.buzz_en & colour_bit) != 3'b000) begin
      buzz_phase_nxt = buzz_inc;
      if (buzz_inc == on_count) begin
        drive_nxt  = 1'b0;
        volume_nxt = 1'b1;
      end
      if (buzz_inc >= end_count) begin
        buzz_phase_nxt = '0;
        if (loud) begin
          drive_nxt = 1'b1;
        end else begin
          volume_nxt = 1'b0;
        end
      end
    end else begin
      drive_nxt  = 1'b0;
      volume_nxt = 1'b1;
    end

    // center green blink
    half            = (work_mode == MODE_NORMAL) ? NORMAL_HALF : SETTING_HALF;
    full            = (work_mode == MODE_NORMAL) ? NORMAL_FULL : SETTING_FULL;
    green_inc       = green_phase_r + GREEN_W'(1);
    green_phase_nxt = green_phase_r;
    green_nxt       = 1'b0;
    if (work_mode == MODE_NORMAL || work_mode == MODE_SETTING) begin
      green_phase_nxt = green_inc;
      green_nxt       = green_r;
      if (green_inc == half) begin
        green_nxt = 1'b1;
      end
      if (green_inc >= full) begin
        green_phase_nxt = '0;
        green_nxt       = 1'b0;
      end
    end

    res.lamp         = lamp_nxt;
    res.led_mask     = led_pattern_nxt;
    res.buzzer_drive = drive_nxt;
    res.volume_max   = volume_nxt;
    res.center_green = green_nxt;
    res.relay        = colour && (cfg.relay_en & colour_bit) != 3'b000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chase_wait_r  <= '0;
      chase_pos_r   <= '0;
      led_pattern_r <= '0;
      pwm_phase_r   <= '0;
      lamp_r        <= LAMP_NONE;
      buzz_phase_r  <= '0;
      drive_r       <= 1'b0;
      volume_r      <= 1'b1;
      green_phase_r <= '0;
      green_r       <= 1'b0;
    end else if (step) begin
      chase_wait_r  <= chase_wait_nxt;
      chase_pos_r   <= chase_pos_nxt;
      led_pattern_r <= led_pattern_nxt;
      pwm_phase_r   <= pwm_phase_nxt;
      lamp_r        <= lamp_nxt;
      buzz_phase_r  <= buzz_phase_nxt;
      drive_r       <= drive_nxt;
      volume_r      <= volume_nxt;
      green_phase_r <= green_phase_nxt;
      green_r       <= green_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/signal_annunciator_tick_controller.sv */
// Signal annunciator tick controller.
// Each word on the in_ channel is one timer tick carrying the work mode and
// the loud flag; each tick produces exactly one word on the out_ channel with
// the lamp, the 12-led chase mask, buzzer drive and volume, the center green
// led and the relay.
// Both channels handshake with valid and stall: a word moves on a rising edge
// with valid high and stall low. Configuration registers are written through
// cfg_valid/cfg_ready (always ready) by index; the user must write them only
// while no tick is in flight, which the block itself does not enforce.
// Throughput is one tick per cycle while in_stall is low, set by the single
// state update between the state registers and the output register.
// A two-deep output (output register plus skid word) keeps taking ticks while
// the receiver stalls; in_stall rises only once both hold a word, and is
// registered, so it never depends on out_stall in the same cycle.
// Synchronous reset (rst_n low) clears all counters, turns volume to maximum,
// empties the output and restores the register defaults.
`default_nettype none

module signal_annunciator_tick_controller (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [satc_pkg::MODE_W-1:0]      in_work_mode,
  input  wire logic                             in_loud,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [satc_pkg::LAMP_W-1:0]           out_lamp,
  output logic [satc_pkg::LEDS-1:0]             out_led_mask,
  output logic                                  out_buzzer_drive,
  output logic                                  out_volume_max,
  output logic                                  out_center_green,
  output logic                                  out_relay,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [satc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [satc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import satc_pkg::*;

  cfg_t    cfg_r;
  result_t step_res;
  result_t out_res_r;
  result_t skid_res_r;
  logic    out_valid_r;
  logic    skid_valid_r;
  logic    in_acc;
  logic    out_take;
  logic    out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;
  assign out_free  = out_take || !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.group_count <= 3'(GROUPS_RST);
      cfg_r.speed       <= '0;
      cfg_r.brightness  <= 7'(BRIGHT_RST);
      cfg_r.buzz_on     <= '0;
      cfg_r.buzz_off    <= '0;
      cfg_r.buzz_en     <= '0;
      cfg_r.relay_en    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GROUP_COUNT: cfg_r.group_count <= cfg_data[2:0];
        REG_CHASE_SPEED: begin
          // speed saturates so the step period stays positive
          if (cfg_data[6:0] > 7'(SPEED_MAX)) begin
            cfg_r.speed <= 7'(SPEED_MAX);
          end else begin
            cfg_r.speed <= cfg_data[6:0];
          end
        end
        REG_BRIGHTNESS:  cfg_r.brightness <= cfg_data[6:0];
        REG_BUZZ_ON:     cfg_r.buzz_on    <= cfg_data;
        REG_BUZZ_OFF:    cfg_r.buzz_off   <= cfg_data;
        REG_BUZZ_EN:     cfg_r.buzz_en    <= cfg_data[2:0];
        REG_RELAY_EN:    cfg_r.relay_en   <= cfg_data[2:0];
        default:         ;
      endcase
    end
  end

  satc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_acc),
    .work_mode (in_work_mode),
    .loud      (in_loud),
    .cfg       (cfg_r),
    .res       (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  // output word loads from the skid word first, else straight from the core
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res_r <= skid_valid_r ? skid_res_r : step_res;
    end
    if (in_acc && !out_free) begin
      skid_res_r <= step_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_lamp         = out_res_r.lamp;
  assign out_led_mask     = out_res_r.led_mask;
  assign out_buzzer_drive = out_res_r.buzzer_drive;
  assign out_volume_max   = out_res_r.volume_max;
  assign out_center_green = out_res_r.center_green;
  assign out_relay        = out_res_r.relay;

endmodule

`default_nettype wire

/* sv/satc_checker.sv */
`default_nettype none

module satc_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic [satc_pkg::LAMP_W-1:0]      out_lamp,
  input wire logic [satc_pkg::LEDS-1:0]        out_led_mask,
  input wire logic                             out_center_green,
  input wire logic                             out_relay
);

  // output is empty the cycle after reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // an accepted tick always leaves a word on the output next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted tick produced no output word");

  // input only backs up once the output has been held by the receiver
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("in_stall rose without a stalled output");

  // relay belongs to color modes, green blink to setting and normal
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_center_green && out_relay))
    else $error("center green and relay on in the same word");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_lamp) && $stable(out_led_mask)))
    else $error("stalled output word changed");

endmodule

bind signal_annunciator_tick_controller satc_checker u_satc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_lamp         (out_lamp),
  .out_led_mask     (out_led_mask),
  .out_center_green (out_center_green),
  .out_relay        (out_relay)
);

`default_nettype wire

/* sim/satc_result_checker.sv */
`timescale 1ns / 1ps

module satc_result_checker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  input  wire logic                             in_stall,
  input  wire logic [satc_pkg::MODE_W-1:0]      in_work_mode,
  input  wire logic                             in_loud,
  input  wire logic                             out_valid,
  input  wire logic                             out_stall,
  input  wire logic [satc_pkg::LAMP_W-1:0]      out_lamp,
  input  wire logic [satc_pkg::LEDS-1:0]        out_led_mask,
  input  wire logic                             out_buzzer_drive,
  input  wire logic                             out_volume_max,
  input  wire logic                             out_center_green,
  input  wire logic                             out_relay,
  input  wire logic                             cfg_valid,
  input  wire logic                             cfg_ready,
  input  wire logic [satc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [satc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                    fail_count,
  output int                                    pending_words
);
  import satc_pkg::*;

  cfg_t              shadow;
  logic [CHASE_W-1:0] chase_wait;
  logic [POS_W-1:0]   chase_pos;
  logic [LEDS-1:0]    led_pattern;
  logic [PWM_W-1:0]   pwm_phase;
  logic [LAMP_W-1:0]  lamp_state;
  logic [BUZZ_W-1:0]  buzz_phase;
  logic               drive_on;
  logic               volume_high;
  logic [GREEN_W-1:0] green_phase;
  logic               green_on;

  result_t predicted_outputs[$];
  int      mismatches = 0;

  // evenly spaced lit leds on the ring, first one at pos
  function automatic logic [LEDS-1:0] chase_leds(input logic [POS_W-1:0] pos,
                                                 input logic [2:0] groups);
    logic [LEDS-1:0] mask;
    int              spacing;
    mask = '0;
    if (groups >= 3'd1 && groups <= 3'd4 && pos >= 4'd1 && pos <= 4'(LEDS)) begin
      spacing = LEDS / int'(groups);
      for (int k = 0; k < int'(groups); k++) begin
        mask[(int'(pos) - 1 + k * spacing) % LEDS] = 1'b1;
      end
    end
    return mask;
  endfunction

  function automatic void blink_green(input int half);
    green_phase = green_phase + 15'd1;
    if (int'(green_phase) == half) green_on = 1'b1;
    if (int'(green_phase) >= 2 * half) begin
      green_phase = '0;
      green_on    = 1'b0;
    end
  endfunction

  function automatic result_t advance_tick(input logic [MODE_W-1:0] mode, input logic loud);
    result_t    r;
    logic       colour;
    logic [1:0] slot;
    int         period;
    colour = (mode >= MODE_RED) && (mode <= MODE_GREEN);
    slot   = 2'(mode - MODE_RED);

    // chase holds in the maintenance modes, runs in color and undefined modes
    if (mode <= MODE_NORMAL) begin
      led_pattern = '0;
    end else begin
      period = CHASE_BASE - CHASE_STEP * int'(shadow.speed);
      if (int'(chase_wait) >= period) begin
        chase_pos = (chase_pos >= 4'(CHASE_WRAP - 1)) ? 4'd1 : chase_pos + 4'd1;
        if (shadow.speed != '0) led_pattern = chase_leds(chase_pos, shadow.group_count);
        chase_wait = '0;
      end else begin
        chase_wait = chase_wait + 13'd1;
      end
    end

    pwm_phase = pwm_phase + 7'd1;
    if (pwm_phase > shadow.brightness) begin
      lamp_state = LAMP_NONE;
    end else if (colour) begin
      case (mode)
        MODE_RED:    lamp_state = LAMP_RED;
        MODE_YELLOW: lamp_state = LAMP_YELLOW;
        default:     lamp_state = LAMP_GREEN;
      endcase
    end
    if (pwm_phase >= 7'(PWM_PERIOD)) pwm_phase = '0;

    if (colour && shadow.buzz_en[slot]) begin
      buzz_phase = buzz_phase + 24'd1;
      if (int'(buzz_phase) == int'(shadow.buzz_on) * BUZZ_SCALE) begin
        drive_on    = 1'b0;
        volume_high = 1'b1;
      end
      // zero times compare literally, so an empty period restarts every tick
      if (int'(buzz_phase) >= (int'(shadow.buzz_on) + int'(shadow.buzz_off)) * BUZZ_SCALE)
      begin
        buzz_phase = '0;
        if (loud) drive_on = 1'b1;
        else volume_high = 1'b0;
      end
    end else begin
      drive_on    = 1'b0;
      volume_high = 1'b1;
    end

    if (mode == MODE_NORMAL) blink_green(GREEN_NORMAL_HALF);
    else if (mode == MODE_SETTING) blink_green(GREEN_SETTING_HALF);
    else green_on = 1'b0;

    r.lamp         = lamp_state;
    r.led_mask     = led_pattern;
    r.buzzer_drive = drive_on;
    r.volume_max   = volume_high;
    r.center_green = green_on;
    r.relay        = colour && shadow.relay_en[slot];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      shadow.group_count = 3'(GROUPS_RST);
      shadow.speed       = '0;
      shadow.brightness  = 7'(BRIGHT_RST);
      shadow.buzz_on     = '0;
      shadow.buzz_off    = '0;
      shadow.buzz_en     = '0;
      shadow.relay_en    = '0;
      chase_wait  = '0;
      chase_pos   = '0;
      led_pattern = '0;
      pwm_phase   = '0;
      lamp_state  = LAMP_NONE;
      buzz_phase  = '0;
      drive_on    = 1'b0;
      volume_high = 1'b1;
      green_phase = '0;
      green_on    = 1'b0;
      predicted_outputs.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GROUP_COUNT: shadow.group_count = cfg_data[2:0];
          REG_CHASE_SPEED: shadow.speed = (cfg_data[6:0] > 7'(SPEED_MAX)) ?
                                          7'(SPEED_MAX) : cfg_data[6:0];
          REG_BRIGHTNESS:  shadow.brightness = cfg_data[6:0];
          REG_BUZZ_ON:     shadow.buzz_on = cfg_data;
          REG_BUZZ_OFF:    shadow.buzz_off = cfg_data;
          REG_BUZZ_EN:     shadow.buzz_en = cfg_data[2:0];
          REG_RELAY_EN:    shadow.relay_en = cfg_data[2:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        predicted_outputs.push_back(advance_tick(in_work_mode, in_loud));
      end

      if (out_valid && !out_stall) begin
        if (predicted_outputs.size() == 0) begin
          $error("result word with no tick waiting for it");
          mismatches++;
        end else begin
          want = predicted_outputs.pop_front();
          if (out_lamp !== want.lamp) begin
            $error("lamp: expected %0d, got %0d", want.lamp, out_lamp);
            mismatches++;
          end
          if (out_led_mask !== want.led_mask) begin
            $error("led_mask: expected %03h, got %03h", want.led_mask, out_led_mask);
            mismatches++;
          end
          if (out_buzzer_drive !== want.buzzer_drive) begin
            $error("buzzer_drive: expected %0d, got %0d", want.buzzer_drive,
                   out_buzzer_drive);
            mismatches++;
          end
          if (out_volume_max !== want.volume_max) begin
            $error("volume_max: expected %0d, got %0d", want.volume_max, out_volume_max);
            mismatches++;
          end
          if (out_center_green !== want.center_green) begin
            $error("center_green: expected %0d, got %0d", want.center_green,
                   out_center_green);
            mismatches++;
          end
          if (out_relay !== want.relay) begin
            $error("relay: expected %0d, got %0d", want.relay, out_relay);
            mismatches++;
          end
        end
      end
    end
    fail_count    <= mismatches;
    pending_words <= predicted_outputs.size();
  end

endmodule

/* sim/signal_annunciator_tick_controller_tb.sv */
`timescale 1ns / 1ps

module signal_annunciator_tick_controller_tb;
  import satc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 150;

  localparam int STALL_NONE    = 0;
  localparam int STALL_RANDOM  = 1;
  localparam int STALL_PATTERN = 2;

  localparam logic [MODE_W-1:0]    MODE_UNDEF_LO = 3'd6;
  localparam logic [MODE_W-1:0]    MODE_UNDEF_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 3'd7;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [MODE_W-1:0]     in_work_mode = '0;
  logic                  in_loud      = 1'b0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [LAMP_W-1:0]     out_lamp;
  logic [LEDS-1:0]       out_led_mask;
  logic                  out_buzzer_drive;
  logic                  out_volume_max;
  logic                  out_center_green;
  logic                  out_relay;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  int fail_count;
  int pending;
  int cycle_count  = 0;
  int burst_left   = 0;
  bit gaps_on      = 1'b1;
  int stall_style  = STALL_NONE;
  int stall_tick   = 0;
  int holds_asked  = 0;
  int holds_served = 0;
  int hold_left    = 0;

  always #4 clk = ~clk;

  signal_annunciator_tick_controller i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_work_mode     (in_work_mode),
    .in_loud          (in_loud),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_lamp         (out_lamp),
    .out_led_mask     (out_led_mask),
    .out_buzzer_drive (out_buzzer_drive),
    .out_volume_max   (out_volume_max),
    .out_center_green (out_center_green),
    .out_relay        (out_relay),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  satc_result_checker i_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_work_mode     (in_work_mode),
    .in_loud          (in_loud),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_lamp         (out_lamp),
    .out_led_mask     (out_led_mask),
    .out_buzzer_drive (out_buzzer_drive),
    .out_volume_max   (out_volume_max),
    .out_center_green (out_center_green),
    .out_relay        (out_relay),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending_words    (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver side: a long hold-off when asked, otherwise the current stall style
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      out_stall    <= 1'b1;
      hold_left    <= HOLD_CYCLES - 1;
      holds_served <= holds_served + 1;
    end else begin
      case (stall_style)
        STALL_RANDOM:  out_stall <= ($urandom_range(0, 99) < 40);
        STALL_PATTERN: out_stall <= ((stall_tick % 7) < 3);
        default:       out_stall <= 1'b0;
      endcase
    end
  end

  task automatic send_tick(input logic [MODE_W-1:0] mode, input logic loud);
    int gap;
    if (gaps_on) begin
      if (burst_left <= 0) begin
        gap        = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 24);
        repeat (gap) begin
          @(negedge clk);
          in_valid <= 1'b0;
        end
      end
      burst_left--;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_work_mode <= mode;
    in_loud      <= loud;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_regs(input logic [7:0] groups, input logic [7:0] speed,
                              input logic [7:0] bright, input logic [7:0] buzz_on,
                              input logic [7:0] buzz_off, input logic [7:0] buzz_en,
                              input logic [7:0] relay_en);
    wait_idle();
    write_reg(REG_GROUP_COUNT, groups);
    write_reg(REG_CHASE_SPEED, speed);
    write_reg(REG_BRIGHTNESS, bright);
    write_reg(REG_BUZZ_ON, buzz_on);
    write_reg(REG_BUZZ_OFF, buzz_off);
    write_reg(REG_BUZZ_EN, buzz_en);
    write_reg(REG_RELAY_EN, relay_en);
    // index past the register list must be ignored
    write_reg(REG_SPARE, 8'($urandom));
  endtask

  // runs of one mode with random loudness, with stray ticks mixed in
  task automatic random_ticks(input int count);
    int                pick;
    int                run;
    logic [MODE_W-1:0] mode;
    logic              loud;
    while (count > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        case ($urandom_range(0, 2))
          0:       mode = MODE_RED;
          1:       mode = MODE_YELLOW;
          default: mode = MODE_GREEN;
        endcase
      end else if (pick < 85) begin
        case ($urandom_range(0, 2))
          0:       mode = MODE_PRESTART;
          1:       mode = MODE_SETTING;
          default: mode = MODE_NORMAL;
        endcase
      end else begin
        mode = ($urandom_range(0, 1) != 0) ? MODE_UNDEF_HI : MODE_UNDEF_LO;
      end
      run  = $urandom_range(1, 40);
      loud = 1'($urandom_range(0, 1));
      while (run > 0 && count > 0) begin
        if ($urandom_range(0, 99) < 8) loud = ~loud;
        if ($urandom_range(0, 99) < 5) send_tick(3'($urandom_range(0, 7)), loud);
        else send_tick(mode, loud);
        run--;
        count--;
      end
    end
  endtask

  task automatic steady_ticks(input logic [MODE_W-1:0] mode, input int count);
    repeat (count) send_tick(mode, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every mode with both loudness values on the reset settings
    gaps_on     = 1'b1;
    stall_style = STALL_RANDOM;
    for (int m = 0; m < 8; m++) begin
      send_tick(3'(m), 1'b0);
      send_tick(3'(m), 1'b1);
    end

    // saturated speed, brightness past the period, zero buzzer times
    program_regs(8'd3, 8'hFF, 8'd127, 8'd0, 8'd0, 8'd7, 8'd7);
    send_tick(MODE_RED, 1'b1);
    send_tick(MODE_RED, 1'b0);
    send_tick(MODE_YELLOW, 1'b1);
    send_tick(MODE_GREEN, 1'b0);
    send_tick(MODE_UNDEF_LO, 1'b1);
    send_tick(MODE_UNDEF_HI, 1'b0);
    send_tick(MODE_NORMAL, 1'b1);

    program_regs(8'd1, 8'd100, 8'd100, 8'd1, 8'd1, 8'd7, 8'd7);
    random_ticks(60);

    gaps_on     = 1'b0;
    stall_style = STALL_PATTERN;
    program_regs(8'd4, 8'h80, 8'd0, 8'd255, 8'd255, 8'd2, 8'd5);
    random_ticks(60);

    gaps_on     = 1'b1;
    stall_style = STALL_NONE;
    program_regs(8'd0, 8'd99, 8'd50, 8'd0, 8'd2, 8'd5, 8'd2);
    random_ticks(60);

    stall_style = STALL_PATTERN;
    program_regs(8'd7, 8'd100, 8'd1, 8'd2, 8'd0, 8'd1, 8'd4);
    random_ticks(60);

    for (int p = 0; p < 3; p++) begin
      gaps_on     = 1'($urandom_range(0, 1));
      stall_style = $urandom_range(STALL_NONE, STALL_PATTERN);
      program_regs(8'($urandom_range(0, 7)),
                   ($urandom_range(0, 4) != 0) ? 8'($urandom_range(90, 127)) : 8'($urandom),
                   8'($urandom_range(0, 127)), 8'($urandom_range(0, 2)),
                   8'($urandom_range(0, 2)), 8'($urandom_range(0, 7)),
                   8'($urandom_range(0, 7)));
      if (p == 1) begin
        // receiver holds off while the sender keeps offering ticks
        gaps_on = 1'b0;
        holds_asked++;
      end
      random_ticks(60);
    end

    // buzzer with its shortest nonzero on and off times, chase at full speed
    gaps_on     = 1'b1;
    stall_style = STALL_RANDOM;
    program_regs(8'd2, 8'd100, 8'd100, 8'd1, 8'd1, 8'd7, 8'd1);
    random_ticks(200);

    // steady runs in setting, normal and green mode
    gaps_on     = 1'b0;
    stall_style = STALL_NONE;
    steady_ticks(MODE_SETTING, 20);
    steady_ticks(MODE_NORMAL, 20);
    steady_ticks(MODE_GREEN, 20);

    wait_idle();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
